>>> design/dlp_pkg.sv
// ----------------------------------------------------------------------------
// dlp_pkg: shared constants and types for the longest path engine
// Sizes of the graph stores and the state encoding of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package dlp_pkg;
  localparam int MaxNodes = 1024;
  localparam int MaxEdges = 4096;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int LinkW = EdgeW + 1;
  localparam int CountW = NodeW + 1;

  localparam logic CfgNodeCount = 1'b0;
  localparam logic CfgStartValue = 1'b1;

  typedef enum logic [11:0] {
    StClear    = 12'b000000000001,
    StLoad     = 12'b000000000010,
    StScan     = 12'b000000000100,
    StPop      = 12'b000000001000,
    StPopWait  = 12'b000000010000,
    StEdge     = 12'b000000100000,
    StEdgeWait = 12'b000001000000,
    StRelax    = 12'b000010000000,
    StRelaxEdg = 12'b000100000000,
    StRelaxWt  = 12'b001000000000,
    StFinish   = 12'b010000000000,
    StOut      = 12'b100000000000
  } state_e;
endpackage
`default_nettype wire

>>> design/dlp_adder.sv
// ----------------------------------------------------------------------------
// dlp_adder: shared add and compare unit
// Forms a candidate path value and says whether it beats the stored one.
// ----------------------------------------------------------------------------
`default_nettype none
module dlp_adder (
  input  wire logic signed [63:0] base_i,
  input  wire logic signed [31:0] cost_i,
  input  wire logic signed [63:0] held_i,
  output logic signed [63:0] sum_o,
  output logic               gt_o
);
  assign sum_o = base_i + 64'(cost_i);
  assign gt_o  = sum_o > held_i;
endmodule
`default_nettype wire

>>> design/dag_longest_path.sv
// ----------------------------------------------------------------------------
// dag_longest_path: longest path through a weighted DAG
// Appends edges into adjacency lists, orders nodes by Kahn's method and
// relaxes edges in that order with one shared add and compare unit.
// ----------------------------------------------------------------------------
// A last beat starts the ordering and relaxation walk, which runs over the
// single-port edge and node memories. One beat is in work at a time. After
// reset, and after each result, a clearing pass resets heads, in-degree
// counts and reached marks; no beat is taken then.
`default_nettype none
module dag_longest_path (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_index_i,
  input  wire logic [47:0]  cfg_data_i,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [9:0]   src_node_i,
  input  wire logic [9:0]   dst_node_i,
  input  wire logic signed [31:0] edge_weight_i,
  input  wire logic         last_edge_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic signed [63:0] best_value_o,
  output logic              target_reached_o
);
  localparam int NW = dlp_pkg::NodeW;
  localparam int EW = dlp_pkg::EdgeW;
  localparam int LW = dlp_pkg::LinkW;
  localparam int CW = dlp_pkg::CountW;
  localparam logic [LW-1:0] Empty = LW'(dlp_pkg::MaxEdges);

  logic [CW-1:0] node_count_q;
  logic signed [47:0] start_q;

  logic [LW-1:0] head_mem [dlp_pkg::MaxNodes];
  logic [NW-1:0] tgt_mem [dlp_pkg::MaxEdges];
  logic [31:0]   cost_mem [dlp_pkg::MaxEdges];
  logic [LW-1:0] link_mem [dlp_pkg::MaxEdges];
  logic [LW-1:0] pend_mem [dlp_pkg::MaxNodes];
  logic [NW-1:0] queue_mem [dlp_pkg::MaxNodes];
  logic [63:0]   best_mem [dlp_pkg::MaxNodes];
  logic          mark_mem [dlp_pkg::MaxNodes];

  dlp_pkg::state_e st_q;
  logic [CW-1:0] i_q, qh_q, qt_q, n_q;
  logic [LW-1:0] edges_q, e_q;
  logic [NW-1:0] src_q, dst_q;
  logic [31:0]   w_q;
  logic          last_q, sub_q;
  logic signed [63:0] bu_q, res_q;
  logic          hit_q;

  // Registered read ports.
  logic [LW-1:0] head_rd, link_rd, pend_rd;
  logic [NW-1:0] tgt_rd, queue_rd;
  logic [31:0]   cost_rd;
  logic [63:0]   best_rd;
  logic          mark_rd;

  logic signed [63:0] sum;
  logic gt;
  dlp_adder u_add (
    .base_i(bu_q), .cost_i(cost_rd), .held_i(best_rd), .sum_o(sum), .gt_o(gt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CW'(1);
      start_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dlp_pkg::CfgNodeCount: node_count_q <= cfg_data_i[CW-1:0];
        dlp_pkg::CfgStartValue: start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o  = (st_q == dlp_pkg::StLoad) && !sub_q;
  assign out_valid_o = (st_q == dlp_pkg::StOut);
  assign best_value_o = res_q;
  assign target_reached_o = hit_q;

  logic acc;
  assign acc = in_valid_i && in_ready_o;
  logic [NW-1:0] tgt_n;
  assign tgt_n = NW'(n_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= dlp_pkg::StClear;
      i_q <= '0; qh_q <= '0; qt_q <= '0; n_q <= CW'(1);
      edges_q <= '0; sub_q <= 1'b0;
      hit_q <= 1'b0; res_q <= '0;
    end else begin
      case (st_q)
        dlp_pkg::StClear: begin
          edges_q <= '0;
          if (i_q == CW'(dlp_pkg::MaxNodes - 1)) begin
            i_q <= '0;
            st_q <= dlp_pkg::StLoad;
          end else i_q <= i_q + CW'(1);
        end
        dlp_pkg::StLoad: begin
          if (acc) begin
            src_q <= src_node_i; dst_q <= dst_node_i; w_q <= edge_weight_i;
            last_q <= last_edge_i; sub_q <= 1'b1;
          end else if (sub_q) begin
            // Now the head and pending reads for this beat are available.
            sub_q <= 1'b0;
            if (edges_q < LW'(dlp_pkg::MaxEdges)) edges_q <= edges_q + LW'(1);
            if (last_q) begin
              if (node_count_q == '0) n_q <= CW'(1);
              else if (node_count_q > CW'(dlp_pkg::MaxNodes))
                n_q <= CW'(dlp_pkg::MaxNodes);
              else n_q <= node_count_q;
              i_q <= '0; qt_q <= '0; qh_q <= '0;
              // From here on last_q serves as the second wait stage.
              last_q <= 1'b0;
              st_q <= dlp_pkg::StScan;
            end
          end
        end
        dlp_pkg::StScan: begin
          // Pending read of node i_q is registered; sub_q tracks it.
          if (!sub_q) sub_q <= 1'b1;
          else begin
            sub_q <= 1'b0;
            if (pend_rd == '0) qt_q <= qt_q + CW'(1);
            i_q <= i_q + CW'(1);
            if (i_q + CW'(1) == n_q) st_q <= dlp_pkg::StPop;
          end
        end
        dlp_pkg::StPop: begin
          if (qh_q == qt_q) begin
            i_q <= '0;
            st_q <= dlp_pkg::StRelax;
          end else st_q <= dlp_pkg::StPopWait;
        end
        dlp_pkg::StPopWait: begin
          if (!sub_q) sub_q <= 1'b1;
          else begin
            sub_q <= 1'b0;
            e_q <= head_rd;
            qh_q <= qh_q + CW'(1);
            st_q <= dlp_pkg::StEdge;
          end
        end
        dlp_pkg::StEdge: begin
          if (e_q[LW-1]) st_q <= dlp_pkg::StPop;
          else st_q <= dlp_pkg::StEdgeWait;
        end
        dlp_pkg::StEdgeWait: begin
          // First the target/link read, then the pending read of the target.
          if (!sub_q) sub_q <= 1'b1;
          else if (!last_q) last_q <= 1'b1;
          else begin
            sub_q <= 1'b0; last_q <= 1'b0;
            if (CW'(tgt_rd) < n_q && pend_rd != '0 && pend_rd == LW'(1)
                && qt_q < CW'(dlp_pkg::MaxNodes))
              qt_q <= qt_q + CW'(1);
            e_q <= link_rd;
            st_q <= dlp_pkg::StEdge;
          end
        end
        dlp_pkg::StRelax: begin
          if (i_q == qt_q) st_q <= dlp_pkg::StFinish;
          else if (!sub_q) sub_q <= 1'b1;
          else if (!last_q) last_q <= 1'b1;
          else begin
            // queue_rd -> u, then head, mark and best of u are read.
            sub_q <= 1'b0; last_q <= 1'b0;
            i_q <= i_q + CW'(1);
            bu_q <= best_rd;
            e_q <= mark_rd ? head_rd : Empty;
            st_q <= dlp_pkg::StRelaxEdg;
          end
        end
        dlp_pkg::StRelaxEdg: begin
          if (e_q[LW-1]) st_q <= dlp_pkg::StRelax;
          else st_q <= dlp_pkg::StRelaxWt;
        end
        dlp_pkg::StRelaxWt: begin
          if (!sub_q) sub_q <= 1'b1;
          else if (!last_q) last_q <= 1'b1;
          else begin
            sub_q <= 1'b0; last_q <= 1'b0;
            e_q <= link_rd;
            st_q <= dlp_pkg::StRelaxEdg;
          end
        end
        dlp_pkg::StFinish: begin
          if (!sub_q) sub_q <= 1'b1;
          else begin
            sub_q <= 1'b0;
            hit_q <= mark_rd;
            res_q <= mark_rd ? best_rd : '0;
            st_q <= dlp_pkg::StOut;
          end
        end
        dlp_pkg::StOut: begin
          if (out_ready_i) begin
            i_q <= '0;
            st_q <= dlp_pkg::StClear;
          end
        end
        default: st_q <= dlp_pkg::StClear;
      endcase
    end
  end

  // Memory addressing per state.
  logic [NW-1:0] node_a;
  logic [EW-1:0] edge_a;
  always_comb begin
    node_a = NW'(i_q);
    case (st_q)
      dlp_pkg::StLoad: node_a = acc ? src_node_i : src_q;
      dlp_pkg::StPopWait: node_a = queue_rd;
      dlp_pkg::StEdgeWait, dlp_pkg::StRelaxWt: node_a = tgt_rd;
      dlp_pkg::StRelax: node_a = queue_rd;
      dlp_pkg::StFinish: node_a = tgt_n;
      default: node_a = NW'(i_q);
    endcase
    edge_a = e_q[EW-1:0];
  end

  logic [NW-1:0] q_ra;
  assign q_ra = (st_q == dlp_pkg::StRelax) ? NW'(i_q) : NW'(qh_q);

  logic store_ok;
  assign store_ok = (st_q == dlp_pkg::StLoad) && sub_q && !edges_q[LW-1];

  logic relax_wr;
  assign relax_wr = (st_q == dlp_pkg::StRelaxWt) && sub_q && last_q
                    && CW'(tgt_rd) < n_q && (!mark_rd || gt);

  logic [NW-1:0] pend_a;
  assign pend_a = (st_q == dlp_pkg::StLoad) ? (acc ? dst_node_i : dst_q) : node_a;

  always_ff @(posedge clk_i) begin
    // Heads: read node_a, written in clear and load.
    head_rd <= head_mem[node_a];
    if (st_q == dlp_pkg::StClear) head_mem[NW'(i_q)] <= Empty;
    else if (store_ok) head_mem[src_q] <= edges_q;
    // Edge store.
    tgt_rd <= tgt_mem[edge_a];
    cost_rd <= cost_mem[edge_a];
    link_rd <= link_mem[edge_a];
    if (store_ok) begin
      tgt_mem[edges_q[EW-1:0]] <= dst_q;
      cost_mem[edges_q[EW-1:0]] <= w_q;
      link_mem[edges_q[EW-1:0]] <= head_rd;
    end
    // In-degree counts.
    pend_rd <= pend_mem[pend_a];
    if (st_q == dlp_pkg::StClear) pend_mem[NW'(i_q)] <= '0;
    else if (store_ok) pend_mem[dst_q] <= pend_rd + LW'(1);
    else if (st_q == dlp_pkg::StEdgeWait && sub_q && last_q
             && CW'(tgt_rd) < n_q && pend_rd != '0)
      pend_mem[tgt_rd] <= pend_rd - LW'(1);
    // Ready queue.
    queue_rd <= queue_mem[q_ra];
    if (st_q == dlp_pkg::StScan && sub_q && pend_rd == '0)
      queue_mem[NW'(qt_q)] <= NW'(i_q);
    else if (st_q == dlp_pkg::StEdgeWait && sub_q && last_q && CW'(tgt_rd) < n_q
             && pend_rd == LW'(1) && qt_q < CW'(dlp_pkg::MaxNodes))
      queue_mem[NW'(qt_q)] <= tgt_rd;
    // Path values and reached marks.
    best_rd <= best_mem[node_a];
    mark_rd <= mark_mem[node_a];
    if (st_q == dlp_pkg::StClear) mark_mem[NW'(i_q)] <= 1'b0;
    else if (st_q == dlp_pkg::StScan && !sub_q && i_q == '0) begin
      mark_mem[0] <= 1'b1;
      best_mem[0] <= 64'(start_q);
    end else if (relax_wr) begin
      mark_mem[tgt_rd] <= 1'b1;
      best_mem[tgt_rd] <= sum;
    end
  end

  // The pending read in the scan issues when sub_q is low; node 0 mark set then.
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while result held");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(best_value_o))
    else $error("result dropped");
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qh_q <= qt_q) else $error("queue head passed tail");
endmodule
`default_nettype wire

>>> tb/dag_longest_path_tb.sv
// ----------------------------------------------------------------------------
// dag_longest_path_tb: self-checking testbench for the longest path engine
// Streams edge beats into the block, predicts every result in a scoreboard
// with its own graph stores, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module dag_longest_path_tb;

  localparam int WatchLimit = 200000;
  localparam int SettleCycles = 1100;

  typedef struct {
    longint value;
    bit     reached;
  } path_result_t;

  typedef enum int {GraphDag, GraphCyclic, GraphNoise} graph_kind_e;

  // Scoreboard: keeps its own copy of the graph and the registers.
  class path_scoreboard;
    int unsigned    nodes_cfg;
    logic [47:0]    start_cfg;
    int             head[dlp_pkg::MaxNodes];
    int             tgt[dlp_pkg::MaxEdges];
    longint         cost[dlp_pkg::MaxEdges];
    int             link[dlp_pkg::MaxEdges];
    int             stored;
    int             pend[dlp_pkg::MaxNodes];
    int             order[dlp_pkg::MaxNodes];
    longint         best[dlp_pkg::MaxNodes];
    bit             reach[dlp_pkg::MaxNodes];
    path_result_t   expected_q[$];
    int             errors;
    int             results_seen;

    function new();
      nodes_cfg = 1;
      start_cfg = '0;
      errors = 0;
      results_seen = 0;
      clear_graph();
    endfunction

    function void clear_graph();
      for (int i = 0; i < dlp_pkg::MaxNodes; i++) begin
        head[i] = dlp_pkg::MaxEdges;
        pend[i] = 0;
        reach[i] = 0;
      end
      stored = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch @%0t: %s", $time, msg);
    endtask

    function void note_edge(int src, int dst, logic signed [31:0] w, bit last);
      int n, qh, qt, u, t, e;
      longint cand;
      path_result_t r;
      if (stored < dlp_pkg::MaxEdges) begin
        e = stored;
        tgt[e] = dst;
        cost[e] = w;
        link[e] = head[src];
        head[src] = e;
        stored++;
        pend[dst]++;
      end
      if (!last) return;
      n = nodes_cfg;
      if (n == 0) n = 1;
      if (n > dlp_pkg::MaxNodes) n = dlp_pkg::MaxNodes;
      // Kahn ordering; initial ready nodes in index order.
      qh = 0;
      qt = 0;
      for (int i = 0; i < n; i++)
        if (pend[i] == 0) order[qt++] = i;
      while (qh < qt) begin
        u = order[qh++];
        for (e = head[u]; e < dlp_pkg::MaxEdges; e = link[e]) begin
          t = tgt[e];
          if (t >= n) continue;
          if (pend[t] > 0) begin
            pend[t]--;
            if (pend[t] == 0 && qt < dlp_pkg::MaxNodes) order[qt++] = t;
          end
        end
      end
      best[0] = longint'($signed(start_cfg));
      reach[0] = 1;
      for (int i = 0; i < qt; i++) begin
        u = order[i];
        if (!reach[u]) continue;
        for (e = head[u]; e < dlp_pkg::MaxEdges; e = link[e]) begin
          t = tgt[e];
          if (t >= n) continue;
          cand = best[u] + cost[e];
          if (!reach[t] || cand > best[t]) begin
            best[t] = cand;
            reach[t] = 1;
          end
        end
      end
      r.reached = reach[n-1];
      r.value = reach[n-1] ? best[n-1] : 64'sd0;
      expected_q.push_back(r);
      clear_graph();
    endfunction

    task check_result(longint value, bit reached);
      path_result_t r;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat with nothing expected (value %0d)", value));
        return;
      end
      r = expected_q.pop_front();
      if (value !== r.value)
        report($sformatf("best_value %0d, expected %0d", value, r.value));
      if (reached !== r.reached)
        report($sformatf("target_reached %0b, expected %0b", reached, r.reached));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = dlp_pkg::CfgNodeCount;
  logic [47:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [9:0]         src_node_i = '0;
  logic [9:0]         dst_node_i = '0;
  logic signed [31:0] edge_weight_i = '0;
  logic               last_edge_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] best_value_o;
  logic               target_reached_o;

  dag_longest_path dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .src_node_i, .dst_node_i, .edge_weight_i,
    .last_edge_i, .out_valid_o, .out_ready_i, .best_value_o, .target_reached_o
  );

  path_scoreboard sb = new();

  int burst_left = 0;
  int hold_left = 0;
  int items_sent = 0;
  int graphs_sent = 0;
  int idle_cycles = 0;
  int rx_tick = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Monitor both channels and run the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_edge(src_node_i, dst_node_i, edge_weight_i, last_edge_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(best_value_o, target_reached_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == WatchLimit) begin
        $display("watchdog expired after %0d idle cycles", WatchLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: long hold-offs on request, otherwise random stalls with
  // stretches of continuous acceptance.
  always @(negedge clk_i) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_tick[8]) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic send_edge(int src, int dst, logic signed [31:0] w, bit last);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    src_node_i <= src[9:0];
    dst_node_i <= dst[9:0];
    edge_weight_i <= w;
    last_edge_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    items_sent++;
    if (last) graphs_sent++;
  endtask

  // Wait until every expected result has come, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [47:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == dlp_pkg::CfgNodeCount) sb.nodes_cfg = data[10:0];
    else sb.start_cfg = data;
  endtask

  function automatic logic signed [31:0] pick_weight();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 200)) - 100;
  endfunction

  task automatic send_graph(graph_kind_e kind, int count);
    int n, s, d;
    n = sb.nodes_cfg;
    if (n == 0) n = 1;
    if (n > dlp_pkg::MaxNodes) n = dlp_pkg::MaxNodes;
    for (int k = 0; k < count; k++) begin
      case (kind)
        GraphDag: begin
          if (n == 1) begin
            s = 0;
            d = 0;
          end else begin
            s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, n - 2);
            d = $urandom_range(s + 1, n - 1);
          end
        end
        GraphCyclic: begin
          s = $urandom_range(0, n - 1);
          d = $urandom_range(0, n - 1);
        end
        default: begin
          s = $urandom_range(0, 1023);
          d = $urandom_range(0, 1023);
        end
      endcase
      send_edge(s, d, pick_weight(), k == count - 1);
    end
  endtask

  task automatic pick_config();
    logic [47:0] sv;
    int sel;
    sel = $urandom_range(0, 9);
    drain();
    case (sel)
      0: cfg_write(dlp_pkg::CfgNodeCount, 48'd1024);
      1: cfg_write(dlp_pkg::CfgNodeCount, 48'd0);
      2: cfg_write(dlp_pkg::CfgNodeCount, 48'd2047);
      3: cfg_write(dlp_pkg::CfgNodeCount, 48'($urandom_range(0, 2047)));
      default: cfg_write(dlp_pkg::CfgNodeCount, 48'($urandom_range(2, 16)));
    endcase
    sv = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) sv = 48'($signed($urandom_range(0, 1000)) - 500);
    cfg_write(dlp_pkg::CfgStartValue, sv);
  endtask

  initial begin
    int count;
    int kind_sel;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: one node, which is both source and target, self loop.
    send_edge(0, 0, 0, 1'b1);
    // Node count zero acts as one; an edge beyond the graph is ignored.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd0);
    cfg_write(dlp_pkg::CfgStartValue, -48'sd5);
    send_edge(1023, 1023, -1, 1'b1);
    // Node count saturates at the store size; extreme weights and start.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd2047);
    cfg_write(dlp_pkg::CfgStartValue, 48'h7FFF_FFFF_FFFF);
    send_edge(0, 1023, 32'sh7FFF_FFFF, 1'b0);
    send_edge(0, 1023, 32'sh8000_0000, 1'b1);
    // Small DAG with a node that is not reachable from the source.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd4);
    cfg_write(dlp_pkg::CfgStartValue, 48'h8000_0000_0000);
    send_edge(0, 1, 10, 1'b0);
    send_edge(1, 3, -3, 1'b0);
    send_edge(0, 3, 5, 1'b0);
    send_edge(2, 3, 100, 1'b1);
    // A cycle blocks the target from being ordered.
    send_edge(0, 1, 1, 1'b0);
    send_edge(1, 2, 1, 1'b0);
    send_edge(2, 1, 1, 1'b0);
    send_edge(2, 3, 1, 1'b1);
    // Target with no path from the source.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd3);
    send_edge(1, 2, 5, 1'b1);

    // Fill the edge store; the beats beyond it are dropped, but the last still starts work.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd8);
    cfg_write(dlp_pkg::CfgStartValue, 48'd0);
    send_graph(GraphDag, dlp_pkg::MaxEdges + 4);

    // Long receiver hold-off while graphs keep arriving, then a full pause.
    drain();
    cfg_write(dlp_pkg::CfgNodeCount, 48'd5);
    hold_left = 3000;
    for (int g = 0; g < 6; g++) send_graph(GraphDag, $urandom_range(1, 4));
    drain();

    while (items_sent < dlp_pkg::MaxEdges + 1200) begin
      if ($urandom_range(0, 7) == 0) pick_config();
      kind_sel = $urandom_range(0, 9);
      count = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 80)
                                           : $urandom_range(1, 12);
      if (kind_sel < 7) send_graph(GraphDag, count);
      else if (kind_sel < 9) send_graph(GraphCyclic, count);
      else send_graph(GraphNoise, count);
    end

    drain();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("Covered %0d edge beats in %0d graphs, %0d results checked.",
             items_sent, graphs_sent, sb.results_seen);
    $display("Included store overflow, cycles, clamped node counts and a long output stall.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
design/dlp_pkg.sv
design/dlp_adder.sv
design/dag_longest_path.sv
tb/dag_longest_path_tb.sv
